// ===== rtl/core/mkcl_pkg.sv =====
// Shared types, constants and key tables for the multi-tap keypad code lock.
`default_nettype none
package mkcl_pkg;

  localparam int TextDepthDefault = 16;

  localparam int KEY_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;
  localparam int LEN_W   = 5;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PASSWORD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASSWORD_LEN = 2'd2;

  localparam logic [7:0]  IDLE_TIMEOUT_RESET = 8'd100;
  localparam logic [63:0] PASSWORD_RESET     = 64'd14410411783971152;
  localparam logic [3:0]  PASSWORD_LEN_RESET = 4'd7;

  localparam logic [KEY_W-1:0] KEY_DELETE = 5'd4;
  localparam logic [KEY_W-1:0] KEY_ENTER  = 5'd8;
  localparam logic [KEY_W-1:0] KEY_LAST   = 5'd16;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE    = 3'd0,
    EV_SHOWN   = 3'd1,
    EV_COMMIT  = 3'd2,
    EV_DELETE  = 3'd3,
    EV_CORRECT = 3'd4,
    EV_WRONG   = 3'd5,
    EV_FULL    = 3'd6
  } event_kind_t;

  // number of characters on a key, 0 for function keys and unused codes
  function automatic logic [3:0] key_len(input logic [KEY_W-1:0] key);
    logic [3:0] n;
    case (key)
      5'd1:                      n = 4'd6;
      5'd2, 5'd3, 5'd5, 5'd6,
      5'd7, 5'd10:               n = 4'd7;
      5'd9, 5'd11:               n = 4'd9;
      5'd13, 5'd14, 5'd15:       n = 4'd1;
      default:                   n = 4'd0;
    endcase
    return n;
  endfunction

  // key characters, first character in the top byte
  function automatic logic [71:0] key_str(input logic [3:0] k);
    logic [71:0] s;
    case (k)
      4'd1:    s = {".,-?!1", 24'h0};
      4'd2:    s = {"abcABC2", 16'h0};
      4'd3:    s = {"defDEF3", 16'h0};
      4'd5:    s = {"ghiGHI4", 16'h0};
      4'd6:    s = {"jklJKL5", 16'h0};
      4'd7:    s = {"mnoMNO6", 16'h0};
      4'd9:    s = "pqrsPQRS7";
      4'd10:   s = {"tuvTUV8", 16'h0};
      4'd11:   s = "wxyzWXYZ9";
      4'd13:   s = {"*", 64'h0};
      4'd14:   s = {"0", 64'h0};
      4'd15:   s = {"#", 64'h0};
      default: s = 72'h0;
    endcase
    return s;
  endfunction

  function automatic logic [CHAR_W-1:0] key_char(input logic [3:0] k, input logic [3:0] idx);
    logic [71:0] s;
    s = key_str(k) << {idx, 3'b000};
    if (idx >= key_len({1'b0, k}))
      return '0;
    return s[71:64];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mkcl_if.sv =====
// Valid/ready channel interfaces for key/tick words and result words.
`default_nettype none
interface mkcl_cmd_if;
  import mkcl_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [KEY_W-1:0]  key_code;
  modport source (output valid, req_type, key_code, input ready);
  modport sink   (input valid, req_type, key_code, output ready);
endinterface

interface mkcl_evt_if;
  import mkcl_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [CHAR_W-1:0] shown_char;
  logic [LEN_W-1:0]  text_length;
  modport source (output valid, event_kind, shown_char, text_length, input ready);
  modport sink   (input valid, event_kind, shown_char, text_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/multitap_keypad_code_lock.sv =====
// Multi-tap keypad code lock: text entry from key presses and ticks, password check.
//
// Each word on cmd is a key press (req_type 0) or one 10 ms tick (req_type 1) and
// yields exactly one word on evt. A word is handled in the cycle it is accepted and
// its result sits in the output register the next cycle, so one word per cycle is
// taken as long as evt drains; cmd.ready drops only while a result waits unclaimed.
// The text buffer is a RAM whose read port is pointed at the last character ahead
// of time, so delete finds the character already read; the first eight are mirrored
// in flops for the password compare. Configuration writes go straight to the
// registers and must happen while no word is in flight.
`default_nettype none
module multitap_keypad_code_lock
  import mkcl_pkg::*;
#(
  parameter int TEXT_DEPTH = TextDepthDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  mkcl_cmd_if.sink                   cmd,
  mkcl_evt_if.source                 evt
);

  localparam int CNT_W  = $clog2(TEXT_DEPTH + 1);
  localparam int ADDR_W = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int SHADOW = (TEXT_DEPTH < 8) ? TEXT_DEPTH : 8;

  // configuration
  logic [7:0]  idle_timeout;
  logic [63:0] password;
  logic [3:0]  password_len;

  // lock state
  logic [CNT_W-1:0] text_count, text_count_next;
  logic             selecting, selecting_next;
  logic [3:0]       active_key, active_key_next;
  logic [3:0]       tap_index, tap_index_next;
  logic [7:0]       idle_count, idle_count_next;
  logic [CHAR_W-1:0] shadow [SHADOW];

  // buffer RAM and last-character bypass
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CNT_W-1:0]  count_view, count_dec;
  logic [CHAR_W-1:0] rd_data, byp_data, top_char;
  logic              byp;

  logic              accept;
  event_kind_t       kind;
  logic [CHAR_W-1:0] ch;
  logic [7:0]        idle_inc;
  logic [4:0]        tap_inc;
  logic [3:0]        n_taps;
  logic              pw_match;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !evt.valid || evt.ready;
  assign top_char  = byp ? byp_data : rd_data;
  assign wr_addr   = ADDR_W'(text_count);

  // keep the read port on the last character of the buffer as it will be
  assign count_view = accept ? text_count_next : text_count;
  assign count_dec  = count_view - 1'b1;
  assign rd_addr    = ADDR_W'(count_dec);

  mkcl_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (ch),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    pw_match = (password_len <= 4'd8) && (8'(text_count) == 8'(password_len));
    for (int i = 0; i < SHADOW; i++) begin
      if ((CNT_W'(i) < text_count) && (shadow[i] != password[8*i +: 8])) begin
        pw_match = 1'b0;
      end
    end
  end

  always_comb begin
    text_count_next = text_count;
    selecting_next  = selecting;
    active_key_next = active_key;
    tap_index_next  = tap_index;
    idle_count_next = idle_count;
    kind            = EV_NONE;
    ch              = '0;
    wr_en           = 1'b0;
    idle_inc        = (idle_count == 8'hFF) ? idle_count : idle_count + 8'd1;
    n_taps          = key_len(cmd.key_code);
    tap_inc         = {1'b0, tap_index} + 5'd1;

    if (cmd.req_type) begin
      if (selecting) begin
        if (idle_inc < idle_timeout) begin
          idle_count_next = idle_inc;
        end else begin
          selecting_next  = 1'b0;
          idle_count_next = '0;
          tap_index_next  = '0;
          if (text_count >= CNT_W'(TEXT_DEPTH)) begin
            kind = EV_FULL;
          end else begin
            kind            = EV_COMMIT;
            ch              = key_char(active_key, tap_index);
            wr_en           = accept;
            text_count_next = text_count + 1'b1;
          end
        end
      end
    end else if (cmd.key_code != '0 && cmd.key_code <= KEY_LAST) begin
      if (selecting) begin
        // only the key being cycled counts while a selection runs
        if (cmd.key_code == {1'b0, active_key}) begin
          tap_index_next  = (tap_inc >= {1'b0, n_taps}) ? 4'd0 : tap_inc[3:0];
          idle_count_next = '0;
          kind            = EV_SHOWN;
          ch              = key_char(active_key, tap_index_next);
        end
      end else if (n_taps != '0) begin
        selecting_next  = 1'b1;
        active_key_next = cmd.key_code[3:0];
        tap_index_next  = '0;
        idle_count_next = '0;
        kind            = EV_SHOWN;
        ch              = key_char(cmd.key_code[3:0], 4'd0);
      end else if (cmd.key_code == KEY_DELETE) begin
        if (text_count != '0) begin
          text_count_next = text_count - 1'b1;
          kind            = EV_DELETE;
          ch              = top_char;
        end
      end else if (cmd.key_code == KEY_ENTER) begin
        kind            = pw_match ? EV_CORRECT : EV_WRONG;
        text_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RESET;
      password     <= PASSWORD_RESET;
      password_len <= PASSWORD_LEN_RESET;
      text_count   <= '0;
      selecting    <= 1'b0;
      active_key   <= '0;
      tap_index    <= '0;
      idle_count   <= '0;
      byp          <= 1'b0;
      evt.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IDLE_TIMEOUT: idle_timeout <= cfg_wdata[7:0];
          REG_PASSWORD:     password     <= cfg_wdata;
          REG_PASSWORD_LEN: password_len <= cfg_wdata[3:0];
          default:          ;
        endcase
      end
      if (accept) begin
        text_count <= text_count_next;
        selecting  <= selecting_next;
        active_key <= active_key_next;
        tap_index  <= tap_index_next;
        idle_count <= idle_count_next;
        // a RAM read of the entry being written returns its old data
        byp        <= wr_en && (wr_addr == rd_addr);
        evt.valid  <= 1'b1;
      end else if (evt.ready) begin
        evt.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data        <= ch;
      evt.event_kind  <= kind;
      evt.shown_char  <= ch;
      evt.text_length <= LEN_W'(text_count_next);
    end
    for (int i = 0; i < SHADOW; i++) begin
      if (wr_en && text_count == CNT_W'(i)) begin
        shadow[i] <= ch;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mkcl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mkcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
